[rtl/i2cee_pkg.sv]
package i2cee_pkg;

	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CFG_DEVICE_CONTROL   = 2'd0,
		CFG_ADDRESS_BYTES    = 2'd1,
		CFG_WRITE_WAIT_TICKS = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_START1 = 11'b000_0000_0010,
		ST_CTRLW  = 11'b000_0000_0100,
		ST_ADDRH  = 11'b000_0000_1000,
		ST_ADDRL  = 11'b000_0001_0000,
		ST_DATA   = 11'b000_0010_0000,
		ST_START2 = 11'b000_0100_0000,
		ST_CTRLR  = 11'b000_1000_0000,
		ST_RX     = 11'b001_0000_0000,
		ST_STOP   = 11'b010_0000_0000,
		ST_WAIT   = 11'b100_0000_0000
	} stage_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] read_data;
	} res_t;

endpackage

[rtl/i2c_eeprom_access_master.sv]
// Bit-level I2C master for single-byte random writes and reads on a serial EEPROM.
// Input channel (in_valid/in_stall): each transaction is one bus tick from a
// prescaler. func selects tick, start write or start read; a command is only
// taken while idle, otherwise it counts as a plain tick. sda_in is the SDA level
// seen during the tick that just ended.
// Output channel (out_valid/out_stall): exactly one result per input transaction,
// giving the SCL and SDA open-drain levels for the next tick, busy, and on the
// finishing tick done, status and the byte read.
// Each result is registered on acceptance. One tick is accepted every cycle
// while in_stall is low; the state update is one registered bus sequencer step.
// An output register plus a one-entry skid register separate the two sides, so
// a new tick is still accepted while one result waits; in_stall rises only when
// both hold results.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// are meant to be issued while the block is idle.
// Reset (arst_n low) returns to idle with the bus released and restores the
// default control byte, two address bytes and the default program-time wait.
module i2c_eeprom_access_master
	import i2cee_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            func,
	input  logic [15:0]           mem_address,
	input  logic [7:0]            write_data,
	input  logic                  sda_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  scl_release,
	output logic                  sda_release,
	output logic                  busy_res,
	output logic                  done_res,
	output logic                  status,
	output logic [7:0]            read_data
);

	logic [7:0]  device_control_q;
	logic [1:0]  address_bytes_q;
	logic [15:0] write_wait_ticks_q;

	stage_t      stage_q;
	logic        half_q;
	logic [3:0]  tick_q;
	logic [7:0]  shift_q;
	logic [15:0] saved_address_q;
	logic [7:0]  saved_data_q;
	logic        is_read_q;
	logic        nack_seen_q;
	logic [15:0] wait_count_q;

	stage_t      n_stage;
	logic        n_half;
	logic [3:0]  n_tick;
	logic [7:0]  n_shift;
	logic [15:0] n_saved_address;
	logic [7:0]  n_saved_data;
	logic        n_is_read;
	logic        n_nack_seen;
	logic [15:0] n_wait_count;
	logic        enter;
	stage_t      target;
	logic        finish;
	res_t        n_res;

	res_t        res_q;
	res_t        skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	logic        in_acc;
	logic        out_take;

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_control_q   <= 8'd160;
			address_bytes_q    <= 2'd2;
			write_wait_ticks_q <= 16'd16667;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DEVICE_CONTROL:   device_control_q   <= cfg_data[7:0];
				CFG_ADDRESS_BYTES:    address_bytes_q    <= cfg_data[1:0];
				CFG_WRITE_WAIT_TICKS: write_wait_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer step: next state for one tick, then the bus levels it implies.
	always_comb begin
		n_stage         = stage_q;
		n_half          = half_q;
		n_tick          = tick_q;
		n_shift         = shift_q;
		n_saved_address = saved_address_q;
		n_saved_data    = saved_data_q;
		n_is_read       = is_read_q;
		n_nack_seen     = nack_seen_q;
		n_wait_count    = wait_count_q;
		enter           = 1'b0;
		target          = ST_IDLE;
		finish          = 1'b0;

		case (stage_q)
			ST_IDLE: begin
				if (func == FUNC_WRITE || func == FUNC_READ) begin
					n_saved_address = mem_address;
					n_saved_data    = write_data;
					n_is_read       = (func == FUNC_READ);
					n_nack_seen     = 1'b0;
					enter           = 1'b1;
					target          = ST_START1;
				end
			end
			ST_START1, ST_START2, ST_STOP: begin
				if (tick_q < 4'd2) begin
					n_tick = tick_q + 4'd1;
				end else if (stage_q == ST_START1) begin
					enter  = 1'b1;
					target = ST_CTRLW;
				end else if (stage_q == ST_START2) begin
					enter  = 1'b1;
					target = ST_CTRLR;
				end else if (!is_read_q && !nack_seen_q) begin
					n_wait_count = write_wait_ticks_q;
					enter        = 1'b1;
					target       = ST_WAIT;
				end else begin
					finish = 1'b1;
				end
			end
			ST_CTRLW, ST_ADDRH, ST_ADDRL, ST_DATA, ST_CTRLR, ST_RX: begin
				if (!half_q) begin
					n_half = 1'b1;
				end else if (!tick_q[3]) begin
					if (stage_q == ST_RX)
						n_shift = {shift_q[6:0], sda_in};
					n_tick = tick_q + 4'd1;
					n_half = 1'b0;
				end else begin
					// Ninth bit: acknowledge slot; only the first control byte is checked.
					enter = 1'b1;
					case (stage_q)
						ST_CTRLW: begin
							if (sda_in) begin
								n_nack_seen = 1'b1;
								target      = ST_STOP;
							end else begin
								target = (address_bytes_q == 2'd1) ? ST_ADDRL : ST_ADDRH;
							end
						end
						ST_ADDRH: target = ST_ADDRL;
						ST_ADDRL: target = is_read_q ? ST_START2 : ST_DATA;
						ST_CTRLR: target = ST_RX;
						default:  target = ST_STOP;
					endcase
				end
			end
			ST_WAIT: begin
				if (wait_count_q == 16'd0)
					finish = 1'b1;
				else
					n_wait_count = wait_count_q - 16'd1;
			end
			default: begin
				enter  = 1'b1;
				target = ST_IDLE;
			end
		endcase

		if (finish) begin
			enter  = 1'b1;
			target = ST_IDLE;
		end

		if (enter) begin
			n_stage = target;
			n_half  = 1'b0;
			n_tick  = 4'd0;
			case (target)
				ST_CTRLW: n_shift = {device_control_q[7:1], 1'b0};
				ST_ADDRH: n_shift = n_saved_address[15:8];
				ST_ADDRL: n_shift = n_saved_address[7:0];
				ST_DATA:  n_shift = n_saved_data;
				ST_CTRLR: n_shift = {device_control_q[7:1], 1'b1};
				ST_RX:    n_shift = 8'd0;
				default:  ;
			endcase
		end

		n_res.done_res  = finish;
		n_res.status    = finish && nack_seen_q;
		n_res.read_data = (finish && is_read_q && !nack_seen_q) ? shift_q : 8'd0;
		n_res.busy_res  = (n_stage != ST_IDLE);

		case (n_stage)
			ST_START1, ST_START2: begin
				n_res.scl_release = (n_tick != 4'd0);
				n_res.sda_release = (n_tick != 4'd2);
			end
			ST_STOP: begin
				n_res.scl_release = (n_tick != 4'd0);
				n_res.sda_release = (n_tick == 4'd2);
			end
			ST_CTRLW, ST_ADDRH, ST_ADDRL, ST_DATA, ST_CTRLR: begin
				n_res.scl_release = n_half;
				n_res.sda_release = n_tick[3] ? 1'b1 : n_shift[~n_tick[2:0]];
			end
			ST_RX: begin
				n_res.scl_release = n_half;
				n_res.sda_release = 1'b1;
			end
			default: begin
				n_res.scl_release = 1'b1;
				n_res.sda_release = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q         <= ST_IDLE;
			half_q          <= 1'b0;
			tick_q          <= 4'd0;
			shift_q         <= 8'd0;
			saved_address_q <= 16'd0;
			saved_data_q    <= 8'd0;
			is_read_q       <= 1'b0;
			nack_seen_q     <= 1'b0;
			wait_count_q    <= 16'd0;
		end else if (in_acc) begin
			stage_q         <= n_stage;
			half_q          <= n_half;
			tick_q          <= n_tick;
			shift_q         <= n_shift;
			saved_address_q <= n_saved_address;
			saved_data_q    <= n_saved_data;
			is_read_q       <= n_is_read;
			nack_seen_q     <= n_nack_seen;
			wait_count_q    <= n_wait_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_acc;
				end
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q)
				res_q <= skid_q;
			else if (in_acc)
				res_q <= n_res;
		end else if (in_acc) begin
			skid_q <= n_res;
		end
	end

	assign scl_release = res_q.scl_release;
	assign sda_release = res_q.sda_release;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;
	assign read_data   = res_q.read_data;

`ifndef SYNTHESIS
	// The skid entry is only ever filled behind a held output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && out_valid_q && out_stall) |=> (skid_valid_q && out_valid_q))
		else $error("transaction accepted behind a stalled result was not kept");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_res) |-> !busy_res)
		else $error("finishing result still reports busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status || read_data != 8'd0)) |-> done_res)
		else $error("status or read data reported without done");

	assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == ST_WAIT) |-> (!is_read_q && !nack_seen_q))
		else $error("program-time wait entered after a read or a refused control byte");
`endif

endmodule

[tb/tb_i2c_eeprom_access_master.sv]
module tb_i2c_eeprom_access_master
	import i2cee_pkg::*;
();

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef enum bit {ROW_OP, ROW_CFG} row_kind_t;

	// One line of the directed script: either a bus operation or a register write.
	// For register rows, code holds the register index and arg the value.
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  code;
		logic [15:0] arg;
		logic [7:0]  wdata;
		bit          nack;
		logic [7:0]  rx;
		bit          noisy;
		bit          typed;
		bit          t_status;
		logic [7:0]  t_data;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            func = FUNC_TICK;
	logic [15:0]           mem_address = '0;
	logic [7:0]            write_data = '0;
	logic                  sda_in = 1'b1;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  scl_release;
	logic                  sda_release;
	logic                  busy_res;
	logic                  done_res;
	logic                  status;
	logic [7:0]            read_data;

	// Predictor state and its copy of the registers.
	stage_t      bus_stage = ST_IDLE;
	logic        clk_high = 1'b0;
	logic [3:0]  bit_idx = '0;
	logic [7:0]  shifter = '0;
	logic [15:0] latched_addr = '0;
	logic [7:0]  latched_data = '0;
	logic        op_is_read = 1'b0;
	logic        ctrl_nacked = 1'b0;
	logic [15:0] wait_left = '0;
	logic [7:0]  ctrl_byte = 8'd160;
	logic [1:0]  addr_len = 2'd2;
	logic [15:0] prog_wait = 16'd16667;

	res_t        pending_res [$];
	res_t        want;
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	bit          pressure_armed = 1'b0;
	bit          pressure_done = 1'b0;
	bit          typed_on = 1'b0;
	bit          typed_status = 1'b0;
	logic [7:0]  typed_data = '0;
	row_t        script [26];
	int unsigned idle_plan [4] = '{0, 60, 0, 10};
	int unsigned stall_plan [4] = '{0, 0, 60, 10};

	i2c_eeprom_access_master uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic void enter(stage_t s);
		bus_stage = s;
		clk_high = 1'b0;
		bit_idx = '0;
		case (s)
			ST_CTRLW: shifter = ctrl_byte & 8'hFE;
			ST_ADDRH: shifter = latched_addr[15:8];
			ST_ADDRL: shifter = latched_addr[7:0];
			ST_DATA:  shifter = latched_data;
			ST_CTRLR: shifter = ctrl_byte | 8'h01;
			ST_RX:    shifter = '0;
			default:  ;
		endcase
	endfunction

	function automatic res_t bus_tick(logic [1:0] f, logic [15:0] a, logic [7:0] d, logic s);
		res_t r;
		bit   fin;
		r = '0;
		fin = 1'b0;
		case (bus_stage)
			ST_IDLE: begin
				if (f == FUNC_WRITE || f == FUNC_READ) begin
					latched_addr = a;
					latched_data = d;
					op_is_read = (f == FUNC_READ);
					ctrl_nacked = 1'b0;
					enter(ST_START1);
				end
			end
			ST_START1, ST_START2, ST_STOP: begin
				if (bit_idx < 2)
					bit_idx++;
				else if (bus_stage == ST_START1)
					enter(ST_CTRLW);
				else if (bus_stage == ST_START2)
					enter(ST_CTRLR);
				else if (!op_is_read && !ctrl_nacked) begin
					wait_left = prog_wait;
					enter(ST_WAIT);
				end else
					fin = 1'b1;
			end
			ST_WAIT: begin
				if (wait_left == 0)
					fin = 1'b1;
				else
					wait_left--;
			end
			default: begin
				if (!clk_high)
					clk_high = 1'b1;
				else if (bit_idx < 8) begin
					if (bus_stage == ST_RX)
						shifter = {shifter[6:0], s};
					bit_idx++;
					clk_high = 1'b0;
				end else begin
					// Only the acknowledge of the first control byte is looked at.
					case (bus_stage)
						ST_CTRLW: begin
							if (s) begin
								ctrl_nacked = 1'b1;
								enter(ST_STOP);
							end else
								enter(addr_len == 2'd1 ? ST_ADDRL : ST_ADDRH);
						end
						ST_ADDRH: enter(ST_ADDRL);
						ST_ADDRL: enter(op_is_read ? ST_START2 : ST_DATA);
						ST_CTRLR: enter(ST_RX);
						default:  enter(ST_STOP);
					endcase
				end
			end
		endcase
		if (fin) begin
			r.done_res = 1'b1;
			r.status = ctrl_nacked;
			r.read_data = (op_is_read && !ctrl_nacked) ? shifter : 8'h00;
			enter(ST_IDLE);
		end
		case (bus_stage)
			ST_START1, ST_START2: begin
				r.scl_release = (bit_idx != 0);
				r.sda_release = (bit_idx != 2);
			end
			ST_STOP: begin
				r.scl_release = (bit_idx != 0);
				r.sda_release = (bit_idx == 2);
			end
			ST_CTRLW, ST_ADDRH, ST_ADDRL, ST_DATA, ST_CTRLR: begin
				r.scl_release = clk_high;
				r.sda_release = (bit_idx < 8) ? shifter[7 - bit_idx] : 1'b1;
			end
			ST_RX: begin
				r.scl_release = clk_high;
				r.sda_release = 1'b1;
			end
			default: begin
				r.scl_release = 1'b1;
				r.sda_release = 1'b1;
			end
		endcase
		r.busy_res = (bus_stage != ST_IDLE);
		return r;
	endfunction

	// SDA as the EEPROM would leave it for the tick about to be sent. Only the
	// control byte acknowledge and the received data bits matter; the rest is noise.
	function automatic logic eeprom_sda(bit nack_plan, logic [7:0] rx_plan);
		if (bus_stage == ST_CTRLW && clk_high && bit_idx == 8)
			return nack_plan;
		if (bus_stage == ST_RX && clk_high && bit_idx < 8)
			return rx_plan[7 - bit_idx];
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic void compare_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d,
			input logic s);
		res_t r;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		mem_address <= a;
		write_data <= d;
		sda_in <= s;
		do @(posedge clk); while (in_stall);
		r = bus_tick(f, a, d, s);
		if (r.busy_res || r.done_res)
			items_sent++;
		if (r.done_res && typed_on) begin
			r.status = typed_status;
			r.read_data = typed_data;
		end
		pending_res.push_back(r);
	endtask

	// Issues one command, then ticks until the sequencer is back in idle.
	task automatic run_op(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d,
			input bit nack_plan, input logic [7:0] rx_plan, input bit noisy);
		logic [1:0] nf;
		send_item(f, a, d, eeprom_sda(nack_plan, rx_plan));
		while (bus_stage != ST_IDLE) begin
			nf = FUNC_TICK;
			if (noisy && $urandom_range(0, 3) == 0)
				nf = 2'($urandom_range(0, 3));
			send_item(nf, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
				eeprom_sda(nack_plan, rx_plan));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_DEVICE_CONTROL: ctrl_byte = v[7:0];
			CFG_ADDRESS_BYTES:  addr_len = v[1:0];
			default:            prog_wait = v;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (pressure_armed && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_res.size() == 0) begin
				$error("result transaction arrived with nothing expected");
				mismatches++;
			end else begin
				want = pending_res.pop_front();
				compare_field("scl_release", 32'(want.scl_release), 32'(scl_release));
				compare_field("sda_release", 32'(want.sda_release), 32'(sda_release));
				compare_field("busy_res", 32'(want.busy_res), 32'(busy_res));
				compare_field("done_res", 32'(want.done_res), 32'(done_res));
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("read_data", 32'(want.read_data), 32'(read_data));
			end
		end
	end

	initial begin
		logic [1:0] pick;
		int unsigned roll;

		// The program-time wait is cleared before the first write to keep the run short.
		script[0]  = '{ROW_CFG, CFG_WRITE_WAIT_TICKS, 16'h0000, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[1]  = '{ROW_OP, FUNC_WRITE, 16'h0000, 8'h00, 0, 8'h00, 0, 1, 0, 8'h00};
		script[2]  = '{ROW_OP, FUNC_WRITE, 16'hFFFF, 8'hFF, 0, 8'h00, 0, 1, 0, 8'h00};
		script[3]  = '{ROW_OP, FUNC_READ, 16'hFFFF, 8'h00, 0, 8'hFF, 0, 1, 0, 8'hFF};
		script[4]  = '{ROW_OP, FUNC_READ, 16'h0000, 8'hFF, 0, 8'h00, 0, 1, 0, 8'h00};
		script[5]  = '{ROW_OP, FUNC_WRITE, 16'h1357, 8'hA5, 1, 8'h00, 0, 1, 1, 8'h00};
		script[6]  = '{ROW_OP, FUNC_READ, 16'h2468, 8'h5A, 1, 8'hC3, 0, 1, 1, 8'h00};
		script[7]  = '{ROW_OP, FUNC_UNUSED, 16'hFFFF, 8'hFF, 0, 8'h00, 0, 0, 0, 8'h00};
		script[8]  = '{ROW_OP, FUNC_TICK, 16'hFFFF, 8'hFF, 0, 8'h00, 0, 0, 0, 8'h00};
		script[9]  = '{ROW_OP, FUNC_READ, 16'hA55A, 8'h00, 0, 8'hA5, 1, 1, 0, 8'hA5};
		script[10] = '{ROW_CFG, CFG_ADDRESS_BYTES, 16'h0001, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[11] = '{ROW_OP, FUNC_WRITE, 16'h1234, 8'h5A, 0, 8'h00, 1, 0, 0, 8'h00};
		script[12] = '{ROW_OP, FUNC_READ, 16'hFF80, 8'h00, 0, 8'h3C, 0, 1, 0, 8'h3C};
		script[13] = '{ROW_CFG, CFG_ADDRESS_BYTES, 16'h0000, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[14] = '{ROW_OP, FUNC_READ, 16'h8001, 8'h00, 0, 8'h81, 0, 0, 0, 8'h00};
		script[15] = '{ROW_CFG, CFG_ADDRESS_BYTES, 16'h0003, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[16] = '{ROW_OP, FUNC_WRITE, 16'h00FF, 8'h81, 0, 8'h00, 0, 0, 0, 8'h00};
		script[17] = '{ROW_CFG, CFG_DEVICE_CONTROL, 16'h00FF, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[18] = '{ROW_OP, FUNC_READ, 16'h4321, 8'h00, 0, 8'h96, 0, 0, 0, 8'h00};
		script[19] = '{ROW_CFG, CFG_DEVICE_CONTROL, 16'h0000, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[20] = '{ROW_OP, FUNC_WRITE, 16'h7FFE, 8'h7E, 0, 8'h00, 1, 0, 0, 8'h00};
		script[21] = '{ROW_CFG, CFG_WRITE_WAIT_TICKS, 16'h0020, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[22] = '{ROW_OP, FUNC_WRITE, 16'h55AA, 8'hC3, 0, 8'h00, 0, 1, 0, 8'h00};
		script[23] = '{ROW_CFG, CFG_WRITE_WAIT_TICKS, 16'h0005, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[24] = '{ROW_CFG, CFG_DEVICE_CONTROL, 16'h00A0, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};
		script[25] = '{ROW_CFG, CFG_ADDRESS_BYTES, 16'h0002, 8'h00, 0, 8'h00, 0, 0, 0, 8'h00};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				settle();
				write_reg(cfg_index_t'(script[i].code), script[i].arg);
			end else begin
				typed_on = script[i].typed;
				typed_status = script[i].t_status;
				typed_data = script[i].t_data;
				run_op(script[i].code, script[i].arg, script[i].wdata, script[i].nack,
					script[i].rx, script[i].noisy);
				typed_on = 1'b0;
			end
		end

		for (int p = 0; p < 4; p++) begin
			settle();
			write_reg(CFG_DEVICE_CONTROL, 16'($urandom_range(0, 255)));
			write_reg(CFG_ADDRESS_BYTES, 16'($urandom_range(0, 3)));
			write_reg(CFG_WRITE_WAIT_TICKS, 16'($urandom_range(0, 8)));
			send_idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			// The long receiver hold-off comes while the sender streams without gaps.
			if (p == 0)
				pressure_armed = 1'b1;
			items_sent = 0;
			while (items_sent < 200) begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					pick = $urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED;
				else if (roll < 54)
					pick = FUNC_WRITE;
				else
					pick = FUNC_READ;
				run_op(pick, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 99) < 15, 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/i2cee_pkg.sv
rtl/i2c_eeprom_access_master.sv
tb/tb_i2c_eeprom_access_master.sv
